// ===== rtl/cpu6502_execute_unit_assert.svh =====
// Assertion macros for the 6502 execute unit.
// Expects clk and rst_n in the scope of the including module.
`ifndef CPU6502_EXECUTE_UNIT_ASSERT_SVH
`define CPU6502_EXECUTE_UNIT_ASSERT_SVH

// checked only out of reset
`define C6502EU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define C6502EU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/c6502eu_pkg.sv =====
// Shared types and constants for the 6502 execute unit.
// Operation codes, status flag positions, register file and result structs.
package c6502eu_pkg;

  localparam int unsigned KindW = 6;
  localparam int unsigned ByteW = 8;

  localparam logic [KindW-1:0] K_ADC  = 6'd0;
  localparam logic [KindW-1:0] K_SBC  = 6'd1;
  localparam logic [KindW-1:0] K_AND  = 6'd2;
  localparam logic [KindW-1:0] K_ORA  = 6'd3;
  localparam logic [KindW-1:0] K_EOR  = 6'd4;
  localparam logic [KindW-1:0] K_BIT  = 6'd5;
  localparam logic [KindW-1:0] K_CMP  = 6'd6;
  localparam logic [KindW-1:0] K_CPX  = 6'd7;
  localparam logic [KindW-1:0] K_CPY  = 6'd8;
  localparam logic [KindW-1:0] K_LDA  = 6'd9;
  localparam logic [KindW-1:0] K_LDX  = 6'd10;
  localparam logic [KindW-1:0] K_LDY  = 6'd11;
  localparam logic [KindW-1:0] K_STA  = 6'd12;
  localparam logic [KindW-1:0] K_STX  = 6'd13;
  localparam logic [KindW-1:0] K_STY  = 6'd14;
  localparam logic [KindW-1:0] K_INC  = 6'd15;
  localparam logic [KindW-1:0] K_DEC  = 6'd16;
  localparam logic [KindW-1:0] K_INX  = 6'd17;
  localparam logic [KindW-1:0] K_INY  = 6'd18;
  localparam logic [KindW-1:0] K_DEX  = 6'd19;
  localparam logic [KindW-1:0] K_DEY  = 6'd20;
  localparam logic [KindW-1:0] K_ASL  = 6'd21;
  localparam logic [KindW-1:0] K_ASLA = 6'd22;
  localparam logic [KindW-1:0] K_LSR  = 6'd23;
  localparam logic [KindW-1:0] K_LSRA = 6'd24;
  localparam logic [KindW-1:0] K_ROL  = 6'd25;
  localparam logic [KindW-1:0] K_ROLA = 6'd26;
  localparam logic [KindW-1:0] K_ROR  = 6'd27;
  localparam logic [KindW-1:0] K_RORA = 6'd28;
  localparam logic [KindW-1:0] K_TAX  = 6'd29;
  localparam logic [KindW-1:0] K_TAY  = 6'd30;
  localparam logic [KindW-1:0] K_TSX  = 6'd31;
  localparam logic [KindW-1:0] K_TXA  = 6'd32;
  localparam logic [KindW-1:0] K_TXS  = 6'd33;
  localparam logic [KindW-1:0] K_TYA  = 6'd34;
  localparam logic [KindW-1:0] K_CLC  = 6'd35;
  localparam logic [KindW-1:0] K_CLD  = 6'd36;
  localparam logic [KindW-1:0] K_CLI  = 6'd37;
  localparam logic [KindW-1:0] K_CLV  = 6'd38;
  localparam logic [KindW-1:0] K_SEC  = 6'd39;
  localparam logic [KindW-1:0] K_SED  = 6'd40;
  localparam logic [KindW-1:0] K_SEI  = 6'd41;
  localparam logic [KindW-1:0] K_BCC  = 6'd42;
  localparam logic [KindW-1:0] K_BCS  = 6'd43;
  localparam logic [KindW-1:0] K_BEQ  = 6'd44;
  localparam logic [KindW-1:0] K_BMI  = 6'd45;
  localparam logic [KindW-1:0] K_BNE  = 6'd46;
  localparam logic [KindW-1:0] K_BPL  = 6'd47;
  localparam logic [KindW-1:0] K_BVC  = 6'd48;
  localparam logic [KindW-1:0] K_BVS  = 6'd49;
  localparam logic [KindW-1:0] K_NOP  = 6'd50;

  // status bit positions
  localparam logic [2:0] FL_C = 3'd0;
  localparam logic [2:0] FL_Z = 3'd1;
  localparam logic [2:0] FL_I = 3'd2;
  localparam logic [2:0] FL_D = 3'd3;
  localparam logic [2:0] FL_B = 3'd4;
  localparam logic [2:0] FL_U = 3'd5;
  localparam logic [2:0] FL_V = 3'd6;
  localparam logic [2:0] FL_N = 3'd7;

  localparam logic [ByteW-1:0] SP_RESET    = 8'hFD;
  localparam logic [ByteW-1:0] FLAGS_RESET = 8'h04;

  typedef struct packed {
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] x;
    logic [ByteW-1:0] y;
    logic [ByteW-1:0] sp;
    logic [ByteW-1:0] p;
  } arch_t;

  typedef struct packed {
    logic [ByteW-1:0] write_data;
    logic             write_valid;
    logic             branch_taken;
  } alu_res_t;

endpackage

// ===== rtl/c6502eu_alu.sv =====
// Single-pass 6502 ALU: next register state and store/branch result.
// Depends on c6502eu_pkg.
module c6502eu_alu (
  input  logic [c6502eu_pkg::KindW-1:0] kind,
  input  logic [c6502eu_pkg::ByteW-1:0] operand,
  input  c6502eu_pkg::arch_t            cur,
  output c6502eu_pkg::arch_t            nxt,
  output c6502eu_pkg::alu_res_t         res
);

  function automatic logic [7:0] with_zn(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p;
    r[c6502eu_pkg::FL_Z] = (v == 8'h00);
    r[c6502eu_pkg::FL_N] = v[7];
    return r;
  endfunction

  logic [7:0] add_m;
  logic [8:0] sum;
  logic       sum_v;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic       is_mem_shift;
  logic       is_rot;
  logic       rot_in;
  logic [7:0] sh_src;
  logic [7:0] shl;
  logic [7:0] shr;
  logic [7:0] inc_m;
  logic [7:0] dec_m;

  always_comb begin
    add_m = (kind == c6502eu_pkg::K_SBC) ? ~operand : operand;
    sum   = {1'b0, cur.a} + {1'b0, add_m} + {8'h00, cur.p[c6502eu_pkg::FL_C]};
    sum_v = ~(cur.a[7] ^ add_m[7]) & (cur.a[7] ^ sum[7]);

    if (kind == c6502eu_pkg::K_CPX) begin
      cmp_reg = cur.x;
    end else if (kind == c6502eu_pkg::K_CPY) begin
      cmp_reg = cur.y;
    end else begin
      cmp_reg = cur.a;
    end
    diff = {1'b0, cmp_reg} - {1'b0, operand};

    is_mem_shift = (kind == c6502eu_pkg::K_ASL) || (kind == c6502eu_pkg::K_LSR) ||
                   (kind == c6502eu_pkg::K_ROL) || (kind == c6502eu_pkg::K_ROR);
    is_rot = (kind == c6502eu_pkg::K_ROL) || (kind == c6502eu_pkg::K_ROLA) ||
             (kind == c6502eu_pkg::K_ROR) || (kind == c6502eu_pkg::K_RORA);
    rot_in = is_rot & cur.p[c6502eu_pkg::FL_C];
    sh_src = is_mem_shift ? operand : cur.a;
    shl    = {sh_src[6:0], rot_in};
    shr    = {rot_in, sh_src[7:1]};
    inc_m  = operand + 8'h01;
    dec_m  = operand - 8'h01;
  end

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (kind)
      c6502eu_pkg::K_ADC, c6502eu_pkg::K_SBC: begin
        nxt.a = sum[7:0];
        nxt.p = with_zn(cur.p, sum[7:0]);
        nxt.p[c6502eu_pkg::FL_C] = sum[8];
        nxt.p[c6502eu_pkg::FL_V] = sum_v;
      end
      c6502eu_pkg::K_AND: begin
        nxt.a = cur.a & operand;
        nxt.p = with_zn(cur.p, cur.a & operand);
      end
      c6502eu_pkg::K_ORA: begin
        nxt.a = cur.a | operand;
        nxt.p = with_zn(cur.p, cur.a | operand);
      end
      c6502eu_pkg::K_EOR: begin
        nxt.a = cur.a ^ operand;
        nxt.p = with_zn(cur.p, cur.a ^ operand);
      end
      c6502eu_pkg::K_BIT: begin
        nxt.p[c6502eu_pkg::FL_Z] = ((cur.a & operand) == 8'h00);
        nxt.p[c6502eu_pkg::FL_N] = operand[7];
        nxt.p[c6502eu_pkg::FL_V] = operand[6];
      end
      c6502eu_pkg::K_CMP, c6502eu_pkg::K_CPX, c6502eu_pkg::K_CPY: begin
        nxt.p = with_zn(cur.p, diff[7:0]);
        nxt.p[c6502eu_pkg::FL_C] = ~diff[8];
      end
      c6502eu_pkg::K_LDA: begin
        nxt.a = operand;
        nxt.p = with_zn(cur.p, operand);
      end
      c6502eu_pkg::K_LDX: begin
        nxt.x = operand;
        nxt.p = with_zn(cur.p, operand);
      end
      c6502eu_pkg::K_LDY: begin
        nxt.y = operand;
        nxt.p = with_zn(cur.p, operand);
      end
      c6502eu_pkg::K_STA: begin
        res.write_data  = cur.a;
        res.write_valid = 1'b1;
      end
      c6502eu_pkg::K_STX: begin
        res.write_data  = cur.x;
        res.write_valid = 1'b1;
      end
      c6502eu_pkg::K_STY: begin
        res.write_data  = cur.y;
        res.write_valid = 1'b1;
      end
      c6502eu_pkg::K_INC: begin
        res.write_data  = inc_m;
        res.write_valid = 1'b1;
        nxt.p = with_zn(cur.p, inc_m);
      end
      c6502eu_pkg::K_DEC: begin
        res.write_data  = dec_m;
        res.write_valid = 1'b1;
        nxt.p = with_zn(cur.p, dec_m);
      end
      c6502eu_pkg::K_INX: begin
        nxt.x = cur.x + 8'h01;
        nxt.p = with_zn(cur.p, cur.x + 8'h01);
      end
      c6502eu_pkg::K_INY: begin
        nxt.y = cur.y + 8'h01;
        nxt.p = with_zn(cur.p, cur.y + 8'h01);
      end
      c6502eu_pkg::K_DEX: begin
        nxt.x = cur.x - 8'h01;
        nxt.p = with_zn(cur.p, cur.x - 8'h01);
      end
      c6502eu_pkg::K_DEY: begin
        nxt.y = cur.y - 8'h01;
        nxt.p = with_zn(cur.p, cur.y - 8'h01);
      end
      c6502eu_pkg::K_ASL, c6502eu_pkg::K_ROL: begin
        res.write_data  = shl;
        res.write_valid = 1'b1;
        nxt.p = with_zn(cur.p, shl);
        nxt.p[c6502eu_pkg::FL_C] = sh_src[7];
      end
      c6502eu_pkg::K_ASLA, c6502eu_pkg::K_ROLA: begin
        nxt.a = shl;
        nxt.p = with_zn(cur.p, shl);
        nxt.p[c6502eu_pkg::FL_C] = sh_src[7];
      end
      c6502eu_pkg::K_LSR, c6502eu_pkg::K_ROR: begin
        res.write_data  = shr;
        res.write_valid = 1'b1;
        nxt.p = with_zn(cur.p, shr);
        nxt.p[c6502eu_pkg::FL_C] = sh_src[0];
      end
      c6502eu_pkg::K_LSRA, c6502eu_pkg::K_RORA: begin
        nxt.a = shr;
        nxt.p = with_zn(cur.p, shr);
        nxt.p[c6502eu_pkg::FL_C] = sh_src[0];
      end
      c6502eu_pkg::K_TAX: begin
        nxt.x = cur.a;
        nxt.p = with_zn(cur.p, cur.a);
      end
      c6502eu_pkg::K_TAY: begin
        nxt.y = cur.a;
        nxt.p = with_zn(cur.p, cur.a);
      end
      c6502eu_pkg::K_TSX: begin
        nxt.x = cur.sp;
        nxt.p = with_zn(cur.p, cur.sp);
      end
      c6502eu_pkg::K_TXA: begin
        nxt.a = cur.x;
        nxt.p = with_zn(cur.p, cur.x);
      end
      c6502eu_pkg::K_TXS: nxt.sp = cur.x;
      c6502eu_pkg::K_TYA: begin
        nxt.a = cur.y;
        nxt.p = with_zn(cur.p, cur.y);
      end
      c6502eu_pkg::K_CLC: nxt.p[c6502eu_pkg::FL_C] = 1'b0;
      c6502eu_pkg::K_CLD: nxt.p[c6502eu_pkg::FL_D] = 1'b0;
      c6502eu_pkg::K_CLI: nxt.p[c6502eu_pkg::FL_I] = 1'b0;
      c6502eu_pkg::K_CLV: nxt.p[c6502eu_pkg::FL_V] = 1'b0;
      c6502eu_pkg::K_SEC: nxt.p[c6502eu_pkg::FL_C] = 1'b1;
      c6502eu_pkg::K_SED: nxt.p[c6502eu_pkg::FL_D] = 1'b1;
      c6502eu_pkg::K_SEI: nxt.p[c6502eu_pkg::FL_I] = 1'b1;
      c6502eu_pkg::K_BCC: res.branch_taken = ~cur.p[c6502eu_pkg::FL_C];
      c6502eu_pkg::K_BCS: res.branch_taken = cur.p[c6502eu_pkg::FL_C];
      c6502eu_pkg::K_BEQ: res.branch_taken = cur.p[c6502eu_pkg::FL_Z];
      c6502eu_pkg::K_BMI: res.branch_taken = cur.p[c6502eu_pkg::FL_N];
      c6502eu_pkg::K_BNE: res.branch_taken = ~cur.p[c6502eu_pkg::FL_Z];
      c6502eu_pkg::K_BPL: res.branch_taken = ~cur.p[c6502eu_pkg::FL_N];
      c6502eu_pkg::K_BVC: res.branch_taken = ~cur.p[c6502eu_pkg::FL_V];
      c6502eu_pkg::K_BVS: res.branch_taken = cur.p[c6502eu_pkg::FL_V];
      default: ; // NOP and unassigned codes
    endcase
  end

endmodule

// ===== rtl/c6502eu_regfile.sv =====
// Architectural registers A, X, Y, SP and P of the execute unit.
// Depends on c6502eu_pkg; loaded from the ALU on each executed request.
module c6502eu_regfile (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  c6502eu_pkg::arch_t state_nxt,
  output c6502eu_pkg::arch_t state
);

  c6502eu_pkg::arch_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.a  <= '0;
      state_r.x  <= '0;
      state_r.y  <= '0;
      state_r.sp <= c6502eu_pkg::SP_RESET;
      state_r.p  <= c6502eu_pkg::FLAGS_RESET;
    end else if (load) begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

// ===== rtl/cpu6502_execute_unit.sv =====
// 6502 execute unit top level: input register, ALU pass, result register.
// Depends on c6502eu_pkg, c6502eu_alu, c6502eu_regfile and the assert header.
//
// Executes one 6502 data, flag, transfer or branch instruction per request.
// Throughput is one request per clock while no result waits untaken:
// each request is held in the input register, where the ALU reads the
// register file and updates it in a single pass, and the result then sits
// in the output register until taken. A request moves on from the input
// register to the output register once the latter is free or being taken.
// The input side keeps accepting while a finished result waits, as long
// as the input register is free or moving on.
// ADC/SBC are binary; D is stored only.

`include "cpu6502_execute_unit_assert.svh"

module cpu6502_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] operand
  input  logic [5:0]  in_tuser,   // [5:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] write_data, [15:8] acc_out, [23:16] x_out, [31:24] y_out,
  // [39:32] flags_out, [47:40] sp_out
  output logic [47:0] out_tdata,
  output logic [1:0]  out_tuser   // [0] write_valid, [1] branch_taken
);

  logic                          stage_valid_r;
  logic [c6502eu_pkg::KindW-1:0] stage_kind_r;
  logic [c6502eu_pkg::ByteW-1:0] stage_operand_r;
  logic                          exec_fire;
  logic                          in_fire;

  c6502eu_pkg::arch_t    state;
  c6502eu_pkg::arch_t    state_nxt;
  c6502eu_pkg::alu_res_t alu_res;

  logic                  out_valid_r;
  c6502eu_pkg::alu_res_t out_res_r;
  c6502eu_pkg::arch_t    out_state_r;

  assign exec_fire = stage_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stage_valid_r || exec_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_tready) begin
      stage_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stage_kind_r    <= in_tuser;
      stage_operand_r <= in_tdata;
    end
  end

  c6502eu_alu u_alu (
    .kind    (stage_kind_r),
    .operand (stage_operand_r),
    .cur     (state),
    .nxt     (state_nxt),
    .res     (alu_res)
  );

  c6502eu_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (exec_fire),
    .state_nxt (state_nxt),
    .state     (state)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_res_r   <= alu_res;
      out_state_r <= state_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_state_r.sp, out_state_r.p, out_state_r.y,
                       out_state_r.x, out_state_r.a, out_res_r.write_data};
  assign out_tuser  = {out_res_r.branch_taken, out_res_r.write_valid};

  `C6502EU_ASSERT(a_exec_fills_out, exec_fire |=> out_valid_r, "executed request lost")
  `C6502EU_ASSERT(a_stall_means_busy, !in_tready |-> (stage_valid_r && out_valid_r), "stall without backlog")
  `C6502EU_ASSERT(a_ub_flags_zero, out_tvalid |-> (out_tdata[37:36] == 2'b00), "U or B flag set")
  `C6502EU_ASSERT(a_store_data_gated, (out_tvalid && !out_tuser[0]) |-> (out_tdata[7:0] == 8'h00), "store data without store")
  `C6502EU_ASSERT_ALWAYS(a_store_not_branch, rst_n |-> !(out_tvalid && out_tuser[0] && out_tuser[1]), "store and branch together")

endmodule
